// ===== rtl/core/interval_sweep_matcher_top_defines.svh =====
// Assertion macros for the interval sweep matcher.
// Build with NO_ASSERTIONS defined to drop every check.
`ifndef INTERVAL_SWEEP_MATCHER_TOP_DEFINES_SVH
`define INTERVAL_SWEEP_MATCHER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Check that is held off while reset is high.
`define ISM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that also covers the reset cycles.
`define ISM_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ISM_ASSERT(lbl, prop, msg)
`define ISM_ASSERT_RST(lbl, prop, msg)

`endif

`endif

// ===== rtl/core/ism_pkg.sv =====
package ism_pkg;

  localparam int MAX_SUBSCRIPTIONS = 64;
  localparam int MAX_UPDATES       = 256;

  localparam int SUB_W    = 64;
  localparam int IDX_W    = 8;
  localparam int ROW_AW   = $clog2(MAX_UPDATES);
  localparam int CFG_W    = 7;
  localparam int SUB_AW   = $clog2(SUB_W);

  localparam logic [CFG_W-1:0] ACTIVE_RESET = CFG_W'(MAX_SUBSCRIPTIONS);

  typedef enum logic [1:0] {
    OP_BEGIN    = 2'd0,
    OP_ENDPOINT = 2'd1,
    OP_READ     = 2'd2,
    OP_CLEAR    = 2'd3
  } opcode_t;

  typedef struct packed {
    opcode_t          opcode;
    logic             is_update;
    logic [IDX_W-1:0] extent_index;
    logic             is_lower;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] row_index;
    logic [SUB_W-1:0] matching_bits;
  } out_item_t;

endpackage

// ===== rtl/core/interval_sweep_matcher_top.sv =====
// Channel  | Direction | Handshake             | Word
// ---------+-----------+-----------------------+------------------------------
// in       | input     | in_valid / in_ready   | in_data  (opcode, index, ...)
// out      | output    | out_valid / out_ready | out_data (row_index, bits)
// cfg      | input     | cfg_valid / cfg_ready | cfg_data (active_subscriptions)
//
// One word per cycle: a word is taken every cycle unless a read result is
// blocked in the output register. A read result is registered in the row memory's
// read port and stage 1 together, then in the output register.
// Reset (rst, synchronous) resets the sweep sets, clears the row valid bits,
// the pipeline and output flags, and sets active_subscriptions to 64; no sweep.
// A read word stalls in stage 1 only while the output register is full and
// out_ready is low; in_ready then drops. cfg is always ready.
`include "interval_sweep_matcher_top_defines.svh"

module interval_sweep_matcher_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  ism_pkg::in_item_t               in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output ism_pkg::out_item_t              out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ism_pkg::CFG_W-1:0]       cfg_data
);

  import ism_pkg::*;

  // What stage 1 does with the row it read.
  typedef enum logic [1:0] {
    S1_NONE,
    S1_OR,
    S1_READ,
    S1_CLEAR
  } s1_kind_t;

  // Configuration and sweep sets.
  logic [CFG_W-1:0]  active_subs;
  logic [SUB_W-1:0]  before_set;
  logic [SUB_W-1:0]  after_set;

  // Non-match row store, one 64-bit row per update extent. Valid bits stand
  // in for the all-zero reset value.
  logic [SUB_W-1:0]  rows_mem [MAX_UPDATES];
  logic [MAX_UPDATES-1:0] row_vld;
  logic [SUB_W-1:0]  rd_q;
  logic              vld_q;

  // Stage 1.
  logic              s1_valid;
  s1_kind_t          s1_kind;
  logic [ROW_AW-1:0] s1_addr;
  logic [IDX_W-1:0]  s1_index;
  logic              s1_row_ok;
  logic [SUB_W-1:0]  s1_operand;

  // Last write seen by the row that stage 1 read (same-edge write/read).
  logic              fwd_valid;
  logic [ROW_AW-1:0] fwd_addr;
  logic [SUB_W-1:0]  fwd_data;

  // Combinational.
  logic              in_fire;
  logic              s1_done;
  logic              out_load;
  logic              row_ok;
  logic [ROW_AW-1:0] in_addr;
  logic [CFG_W-1:0]  live_cnt;
  logic [SUB_W-1:0]  live_mask;
  logic              sub_ok;
  logic [SUB_W-1:0]  sub_bit;
  logic [SUB_W-1:0]  old_row;
  logic              wr_en;
  logic [SUB_W-1:0]  wr_data;
  s1_kind_t          kind_next;
  logic [SUB_W-1:0]  operand_next;

  assign cfg_ready = 1'b1;

  // Saturate the count and build the mask of subscriptions in use.
  always_comb begin
    if (active_subs > CFG_W'(MAX_SUBSCRIPTIONS)) begin
      live_cnt = CFG_W'(MAX_SUBSCRIPTIONS);
    end else begin
      live_cnt = active_subs;
    end
    if (live_cnt >= CFG_W'(SUB_W)) begin
      live_mask = '1;
    end else begin
      live_mask = (SUB_W'(1) << live_cnt[SUB_AW-1:0]) - SUB_W'(1);
    end
  end

  assign row_ok  = ({1'b0, in_data.extent_index} < (IDX_W + 1)'(MAX_UPDATES));
  assign in_addr = in_data.extent_index[ROW_AW-1:0];
  assign sub_ok  = ({1'b0, in_data.extent_index} < (IDX_W + 1)'(live_cnt));
  assign sub_bit = SUB_W'(1) << in_data.extent_index[SUB_AW-1:0];

  // Stage 1 finishes unless it holds a read and the output register is stuck.
  assign s1_done  = !(s1_valid && s1_kind == S1_READ && out_valid && !out_ready);
  assign in_ready = s1_done;
  assign in_fire  = in_valid && in_ready;
  assign out_load = s1_valid && s1_kind == S1_READ && s1_done;

  // Decode for stage 1; the OR operand is the set as it stands now.
  always_comb begin
    kind_next    = S1_NONE;
    operand_next = in_data.is_lower ? before_set : after_set;
    unique case (in_data.opcode)
      OP_BEGIN: kind_next = S1_NONE;
      OP_ENDPOINT: begin
        if (in_data.is_update && row_ok) begin
          kind_next = S1_OR;
        end
      end
      OP_READ:  kind_next = S1_READ;
      OP_CLEAR: begin
        if (row_ok) begin
          kind_next = S1_CLEAR;
        end
      end
      default:  kind_next = S1_NONE;
    endcase
  end

  // Read-modify-write of the row in stage 1, with forwarding.
  always_comb begin
    if (fwd_valid && fwd_addr == s1_addr) begin
      old_row = fwd_data;
    end else if (vld_q) begin
      old_row = rd_q;
    end else begin
      old_row = '0;
    end
    wr_en   = s1_valid && (s1_kind == S1_OR || s1_kind == S1_CLEAR);
    wr_data = (s1_kind == S1_CLEAR) ? '0 : (old_row | s1_operand);
  end

  // Configuration and sweep sets.
  always_ff @(posedge clk) begin
    if (rst) begin
      active_subs <= ACTIVE_RESET;
      before_set  <= '0;
      after_set   <= '1;
    end else begin
      if (cfg_valid && cfg_ready) begin
        active_subs <= cfg_data;
      end
      if (in_fire) begin
        if (in_data.opcode == OP_BEGIN) begin
          before_set <= '0;
          after_set  <= '1;
        end else if (in_data.opcode == OP_ENDPOINT && !in_data.is_update && sub_ok) begin
          if (in_data.is_lower) begin
            after_set <= after_set & ~sub_bit;
          end else begin
            before_set <= before_set | sub_bit;
          end
        end
      end
    end
  end

  // Row memory: one write port from stage 1, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      rows_mem[s1_addr] <= wr_data;
    end
    if (in_fire) begin
      rd_q <= rows_mem[in_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_vld <= '0;
      vld_q   <= 1'b0;
    end else begin
      if (wr_en) begin
        row_vld[s1_addr] <= 1'b1;
      end
      if (in_fire) begin
        vld_q <= row_vld[in_addr];
      end
    end
  end

  // Stage 1 control and forwarding register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      fwd_valid <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid  <= 1'b1;
        fwd_valid <= wr_en;
      end else if (s1_done) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_kind    <= kind_next;
      s1_addr    <= in_addr;
      s1_index   <= in_data.extent_index;
      s1_row_ok  <= row_ok;
      s1_operand <= operand_next;
      fwd_addr   <= s1_addr;
      fwd_data   <= wr_data;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.row_index     <= s1_index;
      out_data.matching_bits <= s1_row_ok ? (~old_row & live_mask) : '0;
    end
  end

  // Checks.
  `ISM_ASSERT_RST(a_reset_clears, rst |=> !s1_valid && !out_valid, "pipeline not cleared by reset")
  `ISM_ASSERT(a_begin_sets, in_fire && in_data.opcode == OP_BEGIN |=> before_set == '0 && after_set == '1, "begin did not reset sweep sets")
  `ISM_ASSERT(a_row_marked, wr_en |=> row_vld[$past(s1_addr)], "written row not marked valid")
  `ISM_ASSERT(a_read_result, out_load |=> out_valid, "read result lost")
  `ISM_ASSERT(a_stall_holds, s1_valid && !s1_done |=> s1_valid && s1_kind == S1_READ, "stalled read left stage 1")

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
  import ism_pkg::*;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_item_t             out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_W-1:0]      cfg_data;

  interval_sweep_matcher_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // One endpoint of a sweep, tagged with its sorted position.
  typedef struct {
    int       pos;
    in_item_t w;
  } mark_t;

  // Shadow of the block: sweep sets, non-match rows, subscription count.
  logic [SUB_W-1:0] before_subs;
  logic [SUB_W-1:0] after_subs;
  logic [SUB_W-1:0] miss_rows [MAX_UPDATES];
  logic [CFG_W-1:0] active_subs;

  out_item_t pending_rows [$];   // read results still owed by the block
  int        mismatches;
  int        words_sent;
  bit        in_burst;           // sender never idles while set
  bit        out_burst;          // receiver never stalls while set

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Subscriptions in use after saturation at the array size.
  function automatic int live_subs();
    return (int'(active_subs) > MAX_SUBSCRIPTIONS) ? MAX_SUBSCRIPTIONS : int'(active_subs);
  endfunction

  function automatic logic [SUB_W-1:0] live_mask();
    int n;
    n = live_subs();
    if (n >= SUB_W) return '1;
    return (64'd1 << n) - 64'd1;
  endfunction

  // Advance the shadow state by one accepted word; queue the row a read owes.
  task automatic sweep_apply(input in_item_t w);
    out_item_t r;
    case (w.opcode)
      OP_BEGIN: begin
        before_subs = '0;
        after_subs  = '1;
      end
      OP_ENDPOINT: begin
        if (!w.is_update) begin
          // subscription index outside the live count is dropped
          if (int'(w.extent_index) < live_subs()) begin
            if (w.is_lower) after_subs[w.extent_index[SUB_AW-1:0]] = 1'b0;
            else            before_subs[w.extent_index[SUB_AW-1:0]] = 1'b1;
          end
        end else begin
          miss_rows[w.extent_index] |= w.is_lower ? before_subs : after_subs;
        end
      end
      OP_READ: begin
        r.row_index     = w.extent_index;
        r.matching_bits = ~miss_rows[w.extent_index] & live_mask();
        pending_rows.push_back(r);
      end
      OP_CLEAR: miss_rows[w.extent_index] = '0;
    endcase
  endtask

  // Word with random don't-care flags; endpoints override them.
  function automatic in_item_t make_word(input opcode_t op, input int idx);
    in_item_t w;
    w.opcode       = op;
    w.is_update    = 1'($urandom);
    w.extent_index = IDX_W'(idx);
    w.is_lower     = 1'($urandom);
    return w;
  endfunction

  function automatic in_item_t ep_word(input logic upd, input int idx, input logic lower);
    in_item_t w;
    w           = make_word(OP_ENDPOINT, idx);
    w.is_update = upd;
    w.is_lower  = lower;
    return w;
  endfunction

  // Send one word: optional gap, then hold valid until accepted.
  // Valid only drops when a gap follows, so back-to-back words never
  // see a low/high pair in one step.
  task automatic push_word(input in_item_t w);
    int gap;
    gap = in_burst ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_ready !== 1'b1);
    sweep_apply(w);
    words_sent++;
  endtask

  // Drop valid and wait until every owed read row has come back.
  task automatic hold_input();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_rows.size() != 0);
  endtask

  // Register write only with the block idle; endpoints have no result, so
  // let the two-stage pipe drain after the last row before the write.
  task automatic set_active_subs(input logic [CFG_W-1:0] v);
    hold_input();
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid   <= 1'b0;
    active_subs  = v;
  endtask

  function automatic void add_extent(ref mark_t marks[$], input logic upd, input int idx);
    int lo;
    int hi;
    lo = $urandom_range(0, 31);
    hi = lo + $urandom_range(0, 15);
    // lower goes in first so a zero-length extent keeps lower ahead of upper
    marks.push_back('{lo, ep_word(upd, idx, 1'b1)});
    marks.push_back('{hi, ep_word(upd, idx, 1'b0)});
  endfunction

  // One matching job: a few dimensions of sorted endpoints, then read and
  // clear the update rows. Now and then a begin or an endpoint goes missing.
  task automatic run_sweep();
    mark_t marks [$];
    int    upd_rows [$];
    int    n;
    int    n_subs;
    int    idx;
    n      = live_subs();
    n_subs = $urandom_range(1, 10);
    repeat ($urandom_range(1, 5)) upd_rows.push_back($urandom_range(0, MAX_UPDATES - 1));
    repeat ($urandom_range(1, 3)) begin
      marks.delete();
      for (int k = 0; k < n_subs; k++) begin
        if (n > 0 && $urandom_range(0, 7) != 0) idx = $urandom_range(0, n - 1);
        else idx = $urandom_range(0, 255);
        add_extent(marks, 1'b0, idx);
      end
      foreach (upd_rows[k]) add_extent(marks, 1'b1, upd_rows[k]);
      if ($urandom_range(0, 7) == 0) marks.delete($urandom_range(0, marks.size() - 1));
      if ($urandom_range(0, 9) != 0) push_word(make_word(OP_BEGIN, $urandom_range(0, 255)));
      for (int p = 0; p < 48; p++) begin
        foreach (marks[k]) begin
          if (marks[k].pos == p) push_word(marks[k].w);
        end
      end
    end
    foreach (upd_rows[k]) push_word(make_word(OP_READ, upd_rows[k]));
    foreach (upd_rows[k]) begin
      if ($urandom_range(0, 3) != 0) begin
        push_word(make_word(OP_CLEAR, upd_rows[k]));
        if ($urandom_range(0, 3) == 0) push_word(make_word(OP_READ, upd_rows[k]));
      end
    end
  endtask

  // Rows right after reset: nothing excluded, every live bit set.
  task automatic test_reset_rows();
    push_word(make_word(OP_READ, 0));
    push_word(make_word(OP_READ, MAX_UPDATES - 1));
  endtask

  // One dimension by hand: index edges, out-of-use indices, clear.
  task automatic test_single_dimension();
    push_word(make_word(OP_BEGIN, 255));
    push_word(ep_word(1'b0, 0, 1'b1));
    push_word(ep_word(1'b0, 63, 1'b1));
    push_word(ep_word(1'b1, 255, 1'b1));
    push_word(ep_word(1'b0, 0, 1'b0));
    push_word(ep_word(1'b1, 0, 1'b1));
    push_word(ep_word(1'b0, 255, 1'b1));   // beyond the subscription array
    push_word(ep_word(1'b0, 64, 1'b0));
    push_word(ep_word(1'b1, 255, 1'b0));
    push_word(ep_word(1'b0, 63, 1'b0));
    push_word(ep_word(1'b1, 0, 1'b0));
    push_word(make_word(OP_READ, 0));
    push_word(make_word(OP_READ, 255));
    push_word(make_word(OP_CLEAR, 255));
    push_word(make_word(OP_READ, 255));
  endtask

  // Count register: none in use, one, saturating values.
  task automatic test_count_extremes();
    set_active_subs('0);
    push_word(ep_word(1'b0, 0, 1'b0));     // ignored with no subscriptions
    push_word(make_word(OP_READ, 7));
    set_active_subs(7'd1);
    push_word(make_word(OP_READ, 0));
    set_active_subs('1);
    push_word(make_word(OP_READ, 255));
    set_active_subs(7'd65);
    push_word(make_word(OP_READ, 0));
  endtask

  // Sender stops until every row is back, then picks up again.
  task automatic test_drain_pause();
    push_word(make_word(OP_READ, $urandom_range(0, 255)));
    push_word(make_word(OP_READ, $urandom_range(0, 255)));
    hold_input();
    repeat ($urandom_range(1, 6)) @(posedge clk);
    push_word(make_word(OP_READ, $urandom_range(0, 255)));
  endtask

  // Sweeps under several counts, with noise words and idle-free stretches.
  task automatic test_random_sweeps();
    logic [CFG_W-1:0] counts [7];
    int               goal;
    counts = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd65, 7'(ACTIVE_RESET), 7'd0};
    counts[6] = 7'($urandom_range(2, 63));
    goal = words_sent;
    foreach (counts[k]) begin
      set_active_subs(counts[k]);
      goal += 186;
      while (words_sent < goal) begin
        in_burst  = ($urandom_range(0, 4) == 0);
        out_burst = ($urandom_range(0, 4) == 0);
        run_sweep();
        repeat ($urandom_range(0, 6))
          push_word(make_word(opcode_t'($urandom_range(0, 3)), $urandom_range(0, 255)));
        if ($urandom_range(0, 15) == 0) test_drain_pause();
      end
    end
    in_burst  = 1'b0;
    out_burst = 1'b0;
  endtask

  // Result side: random stalls on out_ready, compare each word in order.
  initial begin : row_checker
    int        stall;
    out_item_t want;
    out_ready <= 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      stall = out_burst ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      if (pending_rows.size() == 0) begin
        $display("%0t: unexpected row word, row %0d bits %h", $time,
                 out_data.row_index, out_data.matching_bits);
        mismatches++;
      end else begin
        want = pending_rows.pop_front();
        if (out_data.row_index !== want.row_index) begin
          $display("%0t: row_index expected %0d got %0d", $time,
                   want.row_index, out_data.row_index);
          mismatches++;
        end
        if (out_data.matching_bits !== want.matching_bits) begin
          $display("%0t: matching_bits row %0d expected %h got %h", $time,
                   want.row_index, want.matching_bits, out_data.matching_bits);
          mismatches++;
        end
      end
    end
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #5000000;
    $display("tb_top: errors");
    $finish;
  end

  initial begin
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    before_subs = '0;
    after_subs  = '1;
    foreach (miss_rows[r]) miss_rows[r] = '0;
    active_subs = ACTIVE_RESET;
    mismatches  = 0;
    words_sent  = 0;
    in_burst    = 1'b0;
    out_burst   = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_rows();
    test_single_dimension();
    test_count_extremes();
    test_drain_pause();
    test_random_sweeps();

    // drain, then let the pipe settle so a stray word would still show up
    hold_input();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending_rows.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

// ===== interval_sweep_matcher_top.f =====
+incdir+rtl/core
rtl/core/ism_pkg.sv
rtl/core/interval_sweep_matcher_top.sv
tb/tb_top.sv
